/* rtl/bavlr_pkg.sv */
package bavlr_pkg;

  localparam int unsigned TopBorderLinesDef   = 48;
  localparam int unsigned LeftBorderPixelsDef = 48;
  localparam int unsigned FullWidthDef        = 352;
  localparam int unsigned FullHeightDef       = 288;

  localparam int unsigned PaperWidth  = 256;
  localparam int unsigned PaperHeight = 192;

  localparam int unsigned VramAw    = 13;
  localparam int unsigned VramDepth = 1 << VramAw;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_RENDER = 1'b1
  } req_kind_e;

  typedef struct packed {
    req_kind_e         kind;
    logic [VramAw-1:0] mem_address;
    logic [7:0]        mem_data;
    logic              line_in_paper;
    logic [7:0]        paper_row;
    logic [5:0]        column_group;
    logic [2:0]        border_index;
    logic              flash_phase;
  } vq_entry_t;

  typedef struct packed {
    logic      valid;
    vq_entry_t entry;
  } vq_port_t;

  typedef struct packed {
    logic              en;
    logic [VramAw-1:0] addr;
    logic [7:0]        data;
  } vram_wr_t;

  typedef struct packed {
    logic              en;
    logic [VramAw-1:0] bmp_addr;
    logic [VramAw-1:0] att_addr;
  } vram_rd_t;

  function automatic logic [31:0] palette(input logic [3:0] idx);
    logic [31:0] c;
    case (idx)
      4'd0:    c = 32'hff000000;
      4'd1:    c = 32'hffbf0000;
      4'd2:    c = 32'hff0000bf;
      4'd3:    c = 32'hffbf00bf;
      4'd4:    c = 32'hff00bf00;
      4'd5:    c = 32'hffbfbf00;
      4'd6:    c = 32'hff00bfbf;
      4'd7:    c = 32'hffbfbfbf;
      4'd8:    c = 32'hff000000;
      4'd9:    c = 32'hffff3f3f;
      4'd10:   c = 32'hff3f3fff;
      4'd11:   c = 32'hffff3fff;
      4'd12:   c = 32'hff3fff3f;
      4'd13:   c = 32'hffffff3f;
      4'd14:   c = 32'hff3fffff;
      default: c = 32'hffffffff;
    endcase
    return c;
  endfunction

endpackage

/* rtl/bavlr_front.sv */
module bavlr_front #(
  parameter int unsigned TOP_BORDER_LINES = bavlr_pkg::TopBorderLinesDef,
  parameter int unsigned FULL_HEIGHT      = bavlr_pkg::FullHeightDef
) (
  input  logic                      in_valid_i,
  input  logic                      queue_full_i,
  input  logic                      req_type_i,
  input  logic [bavlr_pkg::VramAw-1:0] mem_address_i,
  input  logic [7:0]                mem_data_i,
  input  logic [8:0]                line_number_i,
  input  logic [5:0]                column_group_i,
  input  logic [2:0]                border_index_i,
  input  logic                      flash_phase_i,
  output logic                      in_stall_o,
  output bavlr_pkg::vq_port_t       push_o
);

  localparam logic [9:0] TopLo = 10'(TOP_BORDER_LINES);
  localparam logic [9:0] TopHi = 10'(TOP_BORDER_LINES + bavlr_pkg::PaperHeight);
  localparam logic [9:0] FullH = 10'(FULL_HEIGHT);

  logic [9:0] line_ext;
  logic [9:0] row_full;

  assign line_ext   = {1'b0, line_number_i};
  assign row_full   = line_ext - TopLo;
  assign in_stall_o = queue_full_i;

  // Classify the line once here; the back end only works per pixel.
  always_comb begin
    push_o.valid              = in_valid_i && !queue_full_i;
    push_o.entry.kind         = bavlr_pkg::req_kind_e'(req_type_i);
    push_o.entry.mem_address  = mem_address_i;
    push_o.entry.mem_data     = mem_data_i;
    push_o.entry.line_in_paper = (line_ext < FullH) && (line_ext >= TopLo)
                                 && (line_ext < TopHi);
    push_o.entry.paper_row    = row_full[7:0];
    push_o.entry.column_group = column_group_i;
    push_o.entry.border_index = border_index_i;
    push_o.entry.flash_phase  = flash_phase_i;
  end

endmodule

/* rtl/bavlr_queue.sv */
module bavlr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bavlr_pkg::vq_port_t push_i,
  input  logic                pop_i,
  output logic                full_o,
  output bavlr_pkg::vq_port_t head_o
);

  bavlr_pkg::vq_entry_t           slots_q [bavlr_pkg::QueueDepth];
  logic [bavlr_pkg::QueueAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [bavlr_pkg::QueueAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [bavlr_pkg::QueueAw:0]    count_q, count_d;
  logic                           do_pop;

  assign full_o       = (count_q == (bavlr_pkg::QueueAw+1)'(bavlr_pkg::QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slots_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q + (bavlr_pkg::QueueAw)'(push_i.valid);
    rd_ptr_d = rd_ptr_q + (bavlr_pkg::QueueAw)'(do_pop);
    count_d  = count_q + (bavlr_pkg::QueueAw+1)'(push_i.valid)
                       - (bavlr_pkg::QueueAw+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slots_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

/* rtl/bavlr_vram.sv */
module bavlr_vram (
  input  logic                clk_i,
  input  bavlr_pkg::vram_wr_t wr_i,
  input  bavlr_pkg::vram_rd_t rd_i,
  output logic [7:0]          bmp_data_o,
  output logic [7:0]          att_data_o
);

  logic [7:0] mem [bavlr_pkg::VramDepth];
  logic [7:0] bmp_q;
  logic [7:0] att_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      bmp_q <= mem[rd_i.bmp_addr];
      att_q <= mem[rd_i.att_addr];
    end
  end

  assign bmp_data_o = bmp_q;
  assign att_data_o = att_q;

endmodule

/* rtl/bavlr_back.sv */
module bavlr_back #(
  parameter int unsigned LEFT_BORDER_PIXELS = bavlr_pkg::LeftBorderPixelsDef,
  parameter int unsigned FULL_WIDTH         = bavlr_pkg::FullWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bavlr_pkg::vq_port_t head_i,
  output logic                pop_o,
  output bavlr_pkg::vram_wr_t vram_wr_o,
  output bavlr_pkg::vram_rd_t vram_rd_o,
  input  logic [7:0]          bmp_data_i,
  input  logic [7:0]          att_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [8:0]          pixel_x_o,
  output logic [31:0]         pixel_argb_o,
  output logic                last_pixel_o
);

  localparam logic [9:0] LeftLo = 10'(LEFT_BORDER_PIXELS);
  localparam logic [9:0] LeftHi = 10'(LEFT_BORDER_PIXELS + bavlr_pkg::PaperWidth);
  localparam logic [9:0] FullW  = 10'(FULL_WIDTH);

  logic       is_write, is_render, advance, issue;
  logic [2:0] k_q, k_d;
  logic [9:0] x_ext, px_full;
  logic [7:0] px;
  logic       in_paper;
  logic [12:0] cell_idx;

  // Read stage
  logic       b_valid_q;
  logic [8:0] b_x_q;
  logic       b_paper_q;
  logic [2:0] b_bit_q;
  logic [2:0] b_border_q;
  logic       b_flash_q;
  logic       b_last_q;

  // Output stage
  logic        out_valid_q;
  logic [8:0]  out_x_q;
  logic [31:0] out_argb_q;
  logic        out_last_q;

  logic [7:0]  bits;
  logic        pix_bit;
  logic [3:0]  ink, pap;
  logic [31:0] colour;

  assign is_write  = head_i.valid && (head_i.entry.kind == bavlr_pkg::REQ_WRITE);
  assign is_render = head_i.valid && (head_i.entry.kind == bavlr_pkg::REQ_RENDER);
  assign advance   = !(out_valid_q && out_stall_i);
  assign issue     = is_render && advance;
  assign pop_o     = is_write || (issue && (k_q == 3'd7));
  assign k_d       = issue ? k_q + 3'd1 : k_q;

  // Writes retire in queue order, so later renders see them and earlier ones do not.
  assign vram_wr_o.en   = is_write;
  assign vram_wr_o.addr = head_i.entry.mem_address;
  assign vram_wr_o.data = head_i.entry.mem_data;

  assign x_ext    = {1'b0, head_i.entry.column_group, k_q};
  assign px_full  = x_ext - LeftLo;
  assign px       = px_full[7:0];
  assign in_paper = head_i.entry.line_in_paper && (x_ext < FullW)
                    && (x_ext >= LeftLo) && (x_ext < LeftHi);
  assign cell_idx = {head_i.entry.paper_row, px[7:3]};

  assign vram_rd_o.en       = issue;
  assign vram_rd_o.bmp_addr = {cell_idx[12:11], cell_idx[7:5], cell_idx[10:8], cell_idx[4:0]};
  assign vram_rd_o.att_addr = {3'b110, cell_idx[12:8], cell_idx[4:0]};

  always_comb begin
    bits    = bmp_data_i ^ {8{att_data_i[7] & b_flash_q}};
    pix_bit = bits[3'd7 - b_bit_q];
    ink     = {att_data_i[6], att_data_i[2:0]};
    pap     = {att_data_i[6], att_data_i[5:3]};
    if (b_paper_q) begin
      colour = bavlr_pkg::palette(pix_bit ? ink : pap);
    end else begin
      colour = bavlr_pkg::palette({1'b0, b_border_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (advance) begin
        b_valid_q   <= issue;
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_x_q      <= x_ext[8:0];
      b_paper_q  <= in_paper;
      b_bit_q    <= px[2:0];
      b_border_q <= head_i.entry.border_index;
      b_flash_q  <= head_i.entry.flash_phase;
      b_last_q   <= (k_q == 3'd7);
    end
    if (advance && b_valid_q) begin
      out_x_q    <= b_x_q;
      out_argb_q <= colour;
      out_last_q <= b_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_argb_o = out_argb_q;
  assign last_pixel_o = out_last_q;

endmodule

/* rtl/bitmap_attribute_video_line_renderer_top.sv */
// Bitmap-with-attribute video line renderer.
//
// Input channel (in_valid_i / in_stall_o) carries two kinds of beat. A write
// beat (req_type_i = 0) stores mem_data_i at mem_address_i in the 8 KiB video
// memory and produces nothing. A render beat (req_type_i = 1) produces eight
// pixel beats for one 8-pixel column group of one screen line, leftmost first.
// Output channel (out_valid_o / out_stall_i) moves one pixel per beat; the
// eighth beat of a group carries last_pixel_o.
//
// Beats pass through a four-entry queue in order, so a write never overtakes
// an earlier render. With the queue empty, the first pixel of a render goes
// through the queue, read stage and output stage registers before it is valid.
// Throughput is one pixel per cycle unless the receiver stalls or a write
// beat is at the queue head, set by the single pixel pipeline (issue, memory
// read, colour decode) behind the queue. While the receiver stalls, the pixel
// pipeline holds and the queue keeps taking beats until full; writes at the
// queue head still retire. Reset clears the queue and pipeline valid bits;
// video memory is not cleared and must be written before it is displayed.
module bitmap_attribute_video_line_renderer_top #(
  parameter int unsigned TOP_BORDER_LINES   = bavlr_pkg::TopBorderLinesDef,
  parameter int unsigned LEFT_BORDER_PIXELS = bavlr_pkg::LeftBorderPixelsDef,
  parameter int unsigned FULL_WIDTH         = bavlr_pkg::FullWidthDef,
  parameter int unsigned FULL_HEIGHT        = bavlr_pkg::FullHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [12:0] mem_address_i,
  input  logic [7:0]  mem_data_i,
  input  logic [8:0]  line_number_i,
  input  logic [5:0]  column_group_i,
  input  logic [2:0]  border_index_i,
  input  logic        flash_phase_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  pixel_x_o,
  output logic [31:0] pixel_argb_o,
  output logic        last_pixel_o
);

  bavlr_pkg::vq_port_t push;
  bavlr_pkg::vq_port_t head;
  bavlr_pkg::vram_wr_t vram_wr;
  bavlr_pkg::vram_rd_t vram_rd;
  logic                queue_full;
  logic                pop;
  logic [7:0]          bmp_data;
  logic [7:0]          att_data;

  // Front end: accept beats and classify the line against the paper area.
  bavlr_front #(
    .TOP_BORDER_LINES(TOP_BORDER_LINES),
    .FULL_HEIGHT     (FULL_HEIGHT)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .queue_full_i  (queue_full),
    .req_type_i    (req_type_i),
    .mem_address_i (mem_address_i),
    .mem_data_i    (mem_data_i),
    .line_number_i (line_number_i),
    .column_group_i(column_group_i),
    .border_index_i(border_index_i),
    .flash_phase_i (flash_phase_i),
    .in_stall_o    (in_stall_o),
    .push_o        (push)
  );

  // Decoupling queue between front and back.
  bavlr_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .full_o(queue_full),
    .head_o(head)
  );

  // Video memory: one write port, two registered read ports (bitmap, attribute).
  bavlr_vram u_vram (
    .clk_i     (clk_i),
    .wr_i      (vram_wr),
    .rd_i      (vram_rd),
    .bmp_data_o(bmp_data),
    .att_data_o(att_data)
  );

  // Back end: retire writes, step through the eight pixels of each render.
  bavlr_back #(
    .LEFT_BORDER_PIXELS(LEFT_BORDER_PIXELS),
    .FULL_WIDTH        (FULL_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .vram_wr_o   (vram_wr),
    .vram_rd_o   (vram_rd),
    .bmp_data_i  (bmp_data),
    .att_data_i  (att_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .pixel_x_o   (pixel_x_o),
    .pixel_argb_o(pixel_argb_o),
    .last_pixel_o(last_pixel_o)
  );

endmodule

/* rtl/bavlr_checker.sv */
module bavlr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [8:0]  pixel_x_o,
  input logic [31:0] pixel_argb_o,
  input logic        last_pixel_o
);

  // Pixels of a group follow each other without gaps, x stepping by one.
  a_group_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_pixel_o
    |=> out_valid_o && (pixel_x_o == 9'($past(pixel_x_o) + 9'd1)))
    else $error("pixel group not contiguous");

  // The last pixel sits at the right end of its 8-pixel group.
  a_last_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_pixel_o |-> (pixel_x_o[2:0] == 3'd7))
    else $error("last pixel misaligned");

  a_not_last_unaligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pixel_o |-> (pixel_x_o[2:0] != 3'd7))
    else $error("group end without last pixel");

  // Stalled pixel holds.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
    |=> out_valid_o && $stable(pixel_argb_o) && $stable(pixel_x_o)
        && $stable(last_pixel_o))
    else $error("stalled pixel changed");

endmodule

bind bitmap_attribute_video_line_renderer_top bavlr_checker u_checker (.*);

/* tb/bitmap_attribute_video_line_renderer_top_tb.sv */
module bitmap_attribute_video_line_renderer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: keeps a shadow of video memory, predicts the eight pixels
  // of every accepted render beat and checks the pixel stream in order.
  class pixel_scoreboard;
    typedef struct packed {
      logic [8:0]  x;
      logic [31:0] argb;
      logic        last;
    } pixel_t;

    pixel_t      pending_px[$];
    logic [7:0]  shadow_vram [bavlr_pkg::VramDepth];
    logic [31:0] colour_lut  [16];
    int          mismatches;
    int          writes_seen;
    int          renders_seen;
    int          pixels_checked;
    int          paper_pixels;

    function new();
      colour_lut = '{32'hff000000, 32'hffbf0000, 32'hff0000bf, 32'hffbf00bf,
                     32'hff00bf00, 32'hffbfbf00, 32'hff00bfbf, 32'hffbfbfbf,
                     32'hff000000, 32'hffff3f3f, 32'hff3f3fff, 32'hffff3fff,
                     32'hff3fff3f, 32'hffffff3f, 32'hff3fffff, 32'hffffffff};
      mismatches     = 0;
      writes_seen    = 0;
      renders_seen   = 0;
      pixels_checked = 0;
      paper_pixels   = 0;
    endfunction

    function bit in_paper(logic [8:0] line, logic [9:0] x);
      return line < bavlr_pkg::FullHeightDef && x < bavlr_pkg::FullWidthDef &&
             line >= bavlr_pkg::TopBorderLinesDef &&
             line < bavlr_pkg::TopBorderLinesDef + bavlr_pkg::PaperHeight &&
             x >= bavlr_pkg::LeftBorderPixelsDef &&
             x < bavlr_pkg::LeftBorderPixelsDef + bavlr_pkg::PaperWidth;
    endfunction

    // Bitmap bytes interleave: third, pixel row within cell, cell row, column.
    function logic [12:0] bitmap_addr(logic [7:0] py, logic [7:0] px);
      logic [12:0] cell_idx;
      cell_idx = {py, px[7:3]};
      return {cell_idx[12:11], cell_idx[7:5], cell_idx[10:8], cell_idx[4:0]};
    endfunction

    function logic [12:0] attr_addr(logic [7:0] py, logic [7:0] px);
      logic [12:0] cell_idx;
      cell_idx = {py, px[7:3]};
      return {3'b110, cell_idx[12:8], cell_idx[4:0]};
    endfunction

    function void note_beat(bavlr_pkg::req_kind_e kind, logic [12:0] addr,
                            logic [7:0] data, logic [8:0] line, logic [5:0] group,
                            logic [2:0] border, logic flash);
      pixel_t      px;
      logic [9:0]  x;
      logic [7:0]  py;
      logic [7:0]  pcol;
      logic [7:0]  bits;
      logic [7:0]  attr;
      logic [3:0]  ink;
      logic [3:0]  pap;
      if (kind == bavlr_pkg::REQ_WRITE) begin
        shadow_vram[addr] = data;
        writes_seen++;
        return;
      end
      renders_seen++;
      for (int k = 0; k < 8; k++) begin
        x       = {1'b0, group, 3'b000} + 10'(k);
        px.argb = colour_lut[{1'b0, border}];
        if (in_paper(line, x)) begin
          py   = 8'(line - bavlr_pkg::TopBorderLinesDef);
          pcol = 8'(x - bavlr_pkg::LeftBorderPixelsDef);
          bits = shadow_vram[bitmap_addr(py, pcol)];
          attr = shadow_vram[attr_addr(py, pcol)];
          ink  = {attr[6], attr[2:0]};
          pap  = {attr[6], attr[5:3]};
          if (attr[7] && flash) bits = ~bits;
          px.argb = bits[3'd7 - pcol[2:0]] ? colour_lut[ink] : colour_lut[pap];
          paper_pixels++;
        end
        px.x    = x[8:0];
        px.last = (k == 7);
        pending_px.push_back(px);
      end
    endfunction

    function void check_pixel(logic [8:0] x, logic [31:0] argb, logic last);
      pixel_t want;
      pixels_checked++;
      if (pending_px.size() == 0) begin
        $display("%t: pixel with nothing pending: x=%0d argb=%h last=%b",
                 $time, x, argb, last);
        mismatches++;
        return;
      end
      want = pending_px.pop_front();
      if (x !== want.x) begin
        $display("%t: pixel_x expected %0d actual %0d", $time, want.x, x);
        mismatches++;
      end
      if (argb !== want.argb) begin
        $display("%t: pixel_argb at x=%0d expected %h actual %h",
                 $time, want.x, want.argb, argb);
        mismatches++;
      end
      if (last !== want.last) begin
        $display("%t: last_pixel at x=%0d expected %b actual %b",
                 $time, want.x, want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  bavlr_pkg::req_kind_e req_type = bavlr_pkg::REQ_WRITE;
  logic [12:0]          mem_address = '0;
  logic [7:0]           mem_data = '0;
  logic [8:0]           line_number = '0;
  logic [5:0]           column_group = '0;
  logic [2:0]           border_index = '0;
  logic                 flash_phase = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  logic [8:0]           pixel_x_o;
  logic [31:0]          pixel_argb_o;
  logic                 last_pixel_o;

  pixel_scoreboard sb;

  // Bytes already queued for writing; a render only goes out once every
  // byte it reads is covered here, so unwritten memory is never shown.
  bit vram_loaded [bavlr_pkg::VramDepth];
  int beats_sent = 0;
  int burst_left = 0;
  bit steady_sender = 1'b0;

  bitmap_attribute_video_line_renderer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type),
    .mem_address_i (mem_address),
    .mem_data_i    (mem_data),
    .line_number_i (line_number),
    .column_group_i(column_group),
    .border_index_i(border_index),
    .flash_phase_i (flash_phase),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .pixel_x_o     (pixel_x_o),
    .pixel_argb_o  (pixel_argb_o),
    .last_pixel_o  (last_pixel_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Sample both channels at the clock edge; the values seen here are the ones
  // the block latched, since every input changes only through the NBA region.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall_o)
      sb.note_beat(req_type, mem_address, mem_data, line_number, column_group,
                   border_index, flash_phase);
    if (rst_ni && out_valid_o && !out_stall)
      sb.check_pixel(pixel_x_o, pixel_argb_o, last_pixel_o);
  end

  // Receiver back-pressure: switch every so often between no stall, light and
  // heavy random stall, and long on/off stretches.
  int stall_mode = 0;
  int stall_run = 0;
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    stall_cycles++;
    if (stall_cycles % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 6);
      default: begin
        if (stall_run == 0) begin
          out_stall <= !out_stall;
          stall_run = $urandom_range(1, 15);
        end else begin
          stall_run--;
        end
      end
    endcase
  end

  // Present one beat and hold it until the block takes it. Open a new burst
  // with a random gap unless the sender is in a steady stretch.
  task automatic send_beat(bavlr_pkg::req_kind_e kind, logic [12:0] addr,
                           logic [7:0] data, logic [8:0] line, logic [5:0] group,
                           logic [2:0] border, logic flash);
    int gap;
    if (burst_left == 0) begin
      gap        = steady_sender ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    req_type     <= kind;
    mem_address  <= addr;
    mem_data     <= data;
    line_number  <= line;
    column_group <= group;
    border_index <= border;
    flash_phase  <= flash;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == bavlr_pkg::REQ_WRITE) vram_loaded[addr] = 1'b1;
    beats_sent++;
  endtask

  // Write beat: render fields carry noise the block must ignore.
  task automatic write_byte(logic [12:0] addr, logic [7:0] data);
    send_beat(bavlr_pkg::REQ_WRITE, addr, data, 9'($urandom_range(0, 511)),
              6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
  endtask

  // Render beat: first load any bitmap or attribute byte still unwritten,
  // then issue the group with noise in the write fields.
  task automatic render(logic [8:0] line, logic [5:0] group, logic [2:0] border,
                        logic flash);
    logic [9:0]  x;
    logic [7:0]  py;
    logic [7:0]  pcol;
    logic [12:0] a;
    for (int k = 0; k < 8; k++) begin
      x = {1'b0, group, 3'b000} + 10'(k);
      if (sb.in_paper(line, x)) begin
        py   = 8'(line - bavlr_pkg::TopBorderLinesDef);
        pcol = 8'(x - bavlr_pkg::LeftBorderPixelsDef);
        a    = sb.bitmap_addr(py, pcol);
        if (!vram_loaded[a]) write_byte(a, 8'($urandom_range(0, 255)));
        a    = sb.attr_addr(py, pcol);
        if (!vram_loaded[a]) write_byte(a, 8'($urandom_range(0, 255)));
      end
    end
    send_beat(bavlr_pkg::REQ_RENDER, 13'($urandom_range(0, 8191)),
              8'($urandom_range(0, 255)), line, group, border, flash);
  endtask

  initial begin
    int          choice;
    logic [8:0]  line;
    logic [5:0]  group;
    logic [7:0]  py;
    logic [7:0]  pcol;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: address and data extremes, screen corners, the paper edges,
    // lines and groups past the screen, and a flashing bright cell in both
    // flash phases.
    write_byte(13'h0000, 8'h00);
    write_byte(13'h1fff, 8'hff);
    render(9'd0, 6'd0, 3'd0, 1'b0);
    render(9'd287, 6'd43, 3'd7, 1'b1);
    render(9'd511, 6'd63, 3'd5, 1'b0);
    render(9'd288, 6'd20, 3'd2, 1'b1);
    render(9'd100, 6'd50, 3'd6, 1'b0);
    write_byte(13'h0000, 8'ha5);
    write_byte(13'h1800, 8'hc5);
    render(9'd48, 6'd6, 3'd3, 1'b0);
    render(9'd48, 6'd6, 3'd3, 1'b1);
    write_byte(13'h17ff, 8'h0f);
    write_byte(13'h1aff, 8'h38);
    render(9'd239, 6'd37, 3'd1, 1'b1);
    render(9'd47, 6'd6, 3'd4, 1'b0);
    render(9'd48, 6'd5, 3'd4, 1'b0);
    render(9'd239, 6'd38, 3'd4, 1'b1);
    render(9'd240, 6'd37, 3'd4, 1'b0);

    // Random: mostly paper cells, sometimes with fresh bitmap or attribute
    // content, mixed with renders anywhere on or off the screen, and stray writes.
    while (beats_sent < 360) begin
      steady_sender = (beats_sent >= 200 && beats_sent < 250);
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
        line  = 9'($urandom_range(bavlr_pkg::TopBorderLinesDef,
                                  bavlr_pkg::TopBorderLinesDef
                                  + bavlr_pkg::PaperHeight - 1));
        group = 6'($urandom_range(bavlr_pkg::LeftBorderPixelsDef / 8,
                                  (bavlr_pkg::LeftBorderPixelsDef
                                   + bavlr_pkg::PaperWidth) / 8 - 1));
        py    = 8'(line - bavlr_pkg::TopBorderLinesDef);
        pcol  = 8'({group, 3'b000} - bavlr_pkg::LeftBorderPixelsDef);
        if ($urandom_range(0, 2) == 0)
          write_byte(sb.bitmap_addr(py, pcol), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
          write_byte(sb.attr_addr(py, pcol), 8'($urandom_range(0, 255)));
        render(line, group, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else if (choice < 80) begin
        line  = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 287))
                                            : 9'($urandom_range(0, 511));
        group = 6'($urandom_range(0, 63));
        render(line, group, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        write_byte(13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    // Drain the pixel stream, then give the pipeline time to show any extra.
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Run covered %0d memory writes and %0d render groups.",
             sb.writes_seen, sb.renders_seen);
    $display("%0d pixels compared, %0d of them decoded from paper cells.",
             sb.pixels_checked, sb.paper_pixels);
    if (sb.mismatches == 0)
      $display("bitmap_attribute_video_line_renderer_top verification clean");
    else
      $display("bitmap_attribute_video_line_renderer_top verification failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d pixels still pending.", sb.pending_px.size());
    $display("bitmap_attribute_video_line_renderer_top verification failed");
    $finish;
  end

endmodule
